### rtl/core/ersd_pkg.sv
// shared constants and types for the reversed edge sorter
// field widths, parameter defaults and the per-cycle operation bundle
// no dependencies
package ersd_pkg;

  localparam int NODE_W = 20;
  localparam int TIE_W = 8;
  localparam int CNT_W = 7;
  localparam int WIDE_W = 32;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 56;

  localparam int MAX_EDGES_DEF = 64;
  localparam int NODE_BITS_DEF = 20;

  typedef struct packed {
    logic insert;
    logic merge;
    logic pop;
  } ersd_op_t;

endpackage

### rtl/core/ersd_cell.sv
// one cell of the sorted insertion chain: key, tie byte, count and valid
// depends on ersd_pkg
module ersd_cell #(
  parameter int KEY_W = 2 * ersd_pkg::NODE_BITS_DEF,
  parameter int MAX_EDGES = ersd_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ersd_pkg::ersd_op_t           op,
  input  logic [KEY_W-1:0]             in_key,
  input  logic [ersd_pkg::TIE_W-1:0]   in_tie,
  input  logic                         prev_gt,
  input  logic [KEY_W-1:0]             prev_key,
  input  logic [ersd_pkg::TIE_W-1:0]   prev_tie,
  input  logic [ersd_pkg::CNT_W-1:0]   prev_count,
  input  logic                         prev_valid,
  input  logic [KEY_W-1:0]             next_key,
  input  logic [ersd_pkg::TIE_W-1:0]   next_tie,
  input  logic [ersd_pkg::CNT_W-1:0]   next_count,
  input  logic                         next_valid,
  output logic                         gt,
  output logic                         eq,
  output logic [KEY_W-1:0]             key,
  output logic [ersd_pkg::TIE_W-1:0]   tie,
  output logic [ersd_pkg::CNT_W-1:0]   count,
  output logic                         valid
);

  logic can_bump;

  assign gt = !valid || (key > in_key);
  assign eq = valid && (key == in_key);
  assign can_bump = count < ersd_pkg::CNT_W'(MAX_EDGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.pop) begin
      valid <= next_valid;
    end else if (op.insert && gt) begin
      valid <= prev_gt ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op.pop) begin
      key   <= next_key;
      tie   <= next_tie;
      count <= next_count;
    end else if (op.insert && gt) begin
      if (prev_gt) begin
        key   <= prev_key;
        tie   <= prev_tie;
        count <= prev_count;
      end else begin
        key   <= in_key;
        tie   <= in_tie;
        count <= ersd_pkg::CNT_W'(1);
      end
    end else if (op.merge && eq && can_bump) begin
      count <= count + ersd_pkg::CNT_W'(1);
    end
  end

endmodule

### rtl/core/edge_reverse_sort_dedup.sv
// top level of the reversed edge sorter: chain of insertion cells and drain control
// depends on ersd_pkg and ersd_cell
//
//  channel  dir  fields (low bit first)                              ends with
//  s_*      in   tdata: src_node, dst_node, tie_byte; tlast: last    last edge
//  m_*      out  tdata: out_src, out_dst, out_tie, multiplicity;     last unique edge
//                tlast: out_last; tuser: dropped_flag
//
// one edge per cycle while filling; every cell compares its key with the new edge
// in the same cycle and the chain shifts right by one to open the slot
// after the last edge, results start in the next cycle, one per cycle while m_tready is high, N unique edges
// s_tready is low from the last edge until the final result is taken
// m_tready low holds the head cell; reset empties all cells
module edge_reverse_sort_dedup #(
  parameter int MAX_EDGES = ersd_pkg::MAX_EDGES_DEF,
  parameter int NODE_BITS = ersd_pkg::NODE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ersd_pkg::IN_DATA_W-1:0]    s_tdata,   // src_node, dst_node, tie_byte
  input  logic                              s_tlast,   // last_edge
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ersd_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_src, out_dst, out_tie, multiplicity
  output logic                              m_tlast,   // out_last
  output logic                              m_tuser    // dropped_flag
);

  localparam int KEY_W = 2 * NODE_BITS;
  localparam int NODE_W = ersd_pkg::NODE_W;
  localparam int TIE_W = ersd_pkg::TIE_W;
  localparam int CNT_W = ersd_pkg::CNT_W;
  localparam int WIDE_W = ersd_pkg::WIDE_W;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state, state_next;
  logic overflow;

  logic [WIDE_W-1:0] src_wide, dst_wide, hi_wide, lo_wide;
  logic [KEY_W-1:0] new_key;
  logic [TIE_W-1:0] new_tie;
  logic s_req, m_req, any_eq, full;
  ersd_pkg::ersd_op_t op;

  logic [KEY_W-1:0] key_q [MAX_EDGES];
  logic [TIE_W-1:0] tie_q [MAX_EDGES];
  logic [CNT_W-1:0] count_q [MAX_EDGES];
  logic [MAX_EDGES-1:0] valid_vec, gt_vec, eq_vec;
  logic head_last;

  assign src_wide = WIDE_W'(s_tdata[NODE_W-1:0]);
  assign dst_wide = WIDE_W'(s_tdata[2*NODE_W-1:NODE_W]);
  assign new_key = {dst_wide[NODE_BITS-1:0], src_wide[NODE_BITS-1:0]};
  assign new_tie = s_tdata[2*NODE_W+TIE_W-1:2*NODE_W];

  assign s_tready = (state == ST_FILL);
  assign s_req = s_tvalid && s_tready;
  assign m_req = m_tvalid && m_tready;
  assign any_eq = |eq_vec;
  assign full = valid_vec[MAX_EDGES-1];

  assign op.insert = s_req && !any_eq && !full;
  assign op.merge = s_req && any_eq;
  assign op.pop = m_req;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    logic p_gt, n_valid;
    logic [KEY_W-1:0] p_key, n_key;
    logic [TIE_W-1:0] p_tie, n_tie;
    logic [CNT_W-1:0] p_count, n_count;
    logic p_valid;

    if (i == 0) begin : g_first
      assign p_gt = 1'b0;
      assign p_key = '0;
      assign p_tie = '0;
      assign p_count = '0;
      assign p_valid = 1'b0;
    end else begin : g_mid
      assign p_gt = gt_vec[i-1];
      assign p_key = key_q[i-1];
      assign p_tie = tie_q[i-1];
      assign p_count = count_q[i-1];
      assign p_valid = valid_vec[i-1];
    end

    if (i == MAX_EDGES - 1) begin : g_tail
      assign n_key = '0;
      assign n_tie = '0;
      assign n_count = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_key = key_q[i+1];
      assign n_tie = tie_q[i+1];
      assign n_count = count_q[i+1];
      assign n_valid = valid_vec[i+1];
    end

    ersd_cell #(
      .KEY_W(KEY_W),
      .MAX_EDGES(MAX_EDGES)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .op(op),
      .in_key(new_key),
      .in_tie(new_tie),
      .prev_gt(p_gt),
      .prev_key(p_key),
      .prev_tie(p_tie),
      .prev_count(p_count),
      .prev_valid(p_valid),
      .next_key(n_key),
      .next_tie(n_tie),
      .next_count(n_count),
      .next_valid(n_valid),
      .gt(gt_vec[i]),
      .eq(eq_vec[i]),
      .key(key_q[i]),
      .tie(tie_q[i]),
      .count(count_q[i]),
      .valid(valid_vec[i])
    );
  end

  if (MAX_EDGES > 1) begin : g_last_multi
    assign head_last = !valid_vec[1];
  end else begin : g_last_single
    assign head_last = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (s_req && s_tlast) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (m_req && head_last) state_next = ST_FILL;
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (m_req && head_last) begin
        overflow <= 1'b0;
      end else if (s_req && !any_eq && full) begin
        overflow <= 1'b1;
      end
    end
  end

  assign hi_wide = WIDE_W'(key_q[0][KEY_W-1:NODE_BITS]);
  assign lo_wide = WIDE_W'(key_q[0][NODE_BITS-1:0]);

  assign m_tvalid = (state == ST_DRAIN) && valid_vec[0];
  assign m_tdata = {1'b0, count_q[0], tie_q[0], lo_wide[NODE_W-1:0], hi_wide[NODE_W-1:0]};
  assign m_tlast = head_last;
  assign m_tuser = overflow;

`ifndef SYNTH
  // occupied cells form a prefix of the chain
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied cells do not form a prefix");

  // stored keys are unique
  assert property (@(posedge clk) disable iff (rst) $onehot0(eq_vec))
    else $error("more than one cell matches the incoming key");

  // a merge leaves the occupancy unchanged
  assert property (@(posedge clk) disable iff (rst) op.merge |=> $stable(valid_vec))
    else $error("merge changed cell occupancy");

  // the last edge always yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) (s_req && s_tlast) |=> m_tvalid)
    else $error("no result after last edge");
`endif

endmodule

### sim/reversed_edge_checker.sv
// checker for the reversed edge sorter: watches both stream channels,
// predicts the sorted merged edge lists and compares every result
// depends on ersd_pkg
module reversed_edge_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [ersd_pkg::IN_DATA_W-1:0]  s_tdata,   // src_node, dst_node, tie_byte
  input  logic                           s_tlast,   // last_edge
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [ersd_pkg::OUT_DATA_W-1:0] m_tdata,   // out_src, out_dst, out_tie, multiplicity
  input  logic                           m_tlast,   // out_last
  input  logic                           m_tuser,   // dropped_flag
  output int                             fail_count,
  output int                             open_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ersd_pkg::MAX_EDGES_DEF;
  localparam int NODE_W = ersd_pkg::NODE_W;
  localparam int TIE_W = ersd_pkg::TIE_W;
  localparam int CNT_W = ersd_pkg::CNT_W;
  localparam int KEY_W = 2 * NODE_W;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [TIE_W-1:0]  tie;
    logic [CNT_W-1:0]  mult;
    logic              last;
    logic              dropped;
  } merged_edge_t;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [TIE_W-1:0] tie_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];
  int               used;
  logic             overflow;
  merged_edge_t     merged_q [$];

  task automatic absorb_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                             input logic [TIE_W-1:0] tie, input logic last);
    logic [KEY_W-1:0] key;
    int pos;
    merged_edge_t r;
    key = {dst, src};
    pos = 0;
    while (pos < used && key_mem[pos] < key) pos++;
    if (pos < used && key_mem[pos] == key) begin
      if (cnt_mem[pos] < DEPTH) cnt_mem[pos]++;
    end else if (used >= DEPTH) begin
      overflow = 1'b1;
    end else begin
      for (int k = used; k > pos; k--) begin
        key_mem[k] = key_mem[k-1];
        tie_mem[k] = tie_mem[k-1];
        cnt_mem[k] = cnt_mem[k-1];
      end
      key_mem[pos] = key;
      tie_mem[pos] = tie;
      cnt_mem[pos] = CNT_W'(1);
      used++;
    end
    if (last) begin
      for (int k = 0; k < used; k++) begin
        r.src = key_mem[k][KEY_W-1:NODE_W];
        r.dst = key_mem[k][NODE_W-1:0];
        r.tie = tie_mem[k];
        r.mult = cnt_mem[k];
        r.last = (k == used - 1);
        r.dropped = overflow;
        merged_q.push_back(r);
      end
      used = 0;
      overflow = 1'b0;
    end
  endtask

  task automatic check_result();
    merged_edge_t want;
    merged_edge_t got;
    got.src = m_tdata[NODE_W-1:0];
    got.dst = m_tdata[2*NODE_W-1:NODE_W];
    got.tie = m_tdata[2*NODE_W+TIE_W-1:2*NODE_W];
    got.mult = m_tdata[2*NODE_W+TIE_W+CNT_W-1:2*NODE_W+TIE_W];
    got.last = m_tlast;
    got.dropped = m_tuser;
    if (merged_q.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result: src %h dst %h tie %h mult %0d last %b drop %b",
                 got.src, got.dst, got.tie, got.mult, got.last, got.dropped);
      fail_count++;
    end else begin
      want = merged_q.pop_front();
      if (got.src !== want.src || got.dst !== want.dst || got.tie !== want.tie ||
          got.mult !== want.mult || got.last !== want.last ||
          got.dropped !== want.dropped) begin
        if (fail_count < 10) begin
          $display("mismatch exp: src %h dst %h tie %h mult %0d last %b drop %b",
                   want.src, want.dst, want.tie, want.mult, want.last, want.dropped);
          $display("         got: src %h dst %h tie %h mult %0d last %b drop %b",
                   got.src, got.dst, got.tie, got.mult, got.last, got.dropped);
        end
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    used = 0;
    overflow = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      used = 0;
      overflow = 1'b0;
      merged_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready)
        absorb_edge(s_tdata[NODE_W-1:0], s_tdata[2*NODE_W-1:NODE_W],
                    s_tdata[2*NODE_W+TIE_W-1:2*NODE_W], s_tlast);
    end
    open_results <= merged_q.size();
  end

endmodule

### sim/edge_reverse_sort_dedup_test.sv
// top of the reversed edge sorter testbench: clock, reset, edge list stimulus
// with random idling and back pressure, and the final verdict
// depends on ersd_pkg, edge_reverse_sort_dedup and reversed_edge_checker
module edge_reverse_sort_dedup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ersd_pkg::MAX_EDGES_DEF;
  localparam int NODE_W = ersd_pkg::NODE_W;
  localparam int TIE_W = ersd_pkg::TIE_W;
  localparam int IN_DATA_W = ersd_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ersd_pkg::OUT_DATA_W;
  localparam int ITEM_GOAL = 470;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  int fail_count;
  int open_results;
  int sent = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int hold_left = 0;

  always #1 clk = ~clk;

  edge_reverse_sort_dedup u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  reversed_edge_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 38);
    end
  end

  task automatic send_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                           input logic [TIE_W-1:0] tie, input logic last);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tie, dst, src};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  task automatic send_short_list();
    logic [NODE_W-1:0] ps [4];
    logic [NODE_W-1:0] pd [4];
    int n;
    int pick;
    n = $urandom_range(1, 16);
    for (int j = 0; j < 4; j++) begin
      ps[j] = NODE_W'($urandom());
      pd[j] = (j == 1) ? pd[0] : NODE_W'($urandom());
    end
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(3);
      if ($urandom_range(1))
        send_edge(ps[pick], pd[pick], TIE_W'($urandom()), j == n - 1);
      else
        send_edge(NODE_W'($urandom()), NODE_W'($urandom()), TIE_W'($urandom()),
                  j == n - 1);
    end
  endtask

  // fills the store, then mixes merges into full cells with dropped new keys
  task automatic send_full_list(input logic last_is_new, input logic stall_output);
    logic [NODE_W-1:0] fs [DEPTH];
    logic [NODE_W-1:0] fd [DEPTH];
    int pick;
    for (int i = 0; i < DEPTH; i++) begin
      fs[i] = NODE_W'($urandom());
      fd[i] = (i % 3 == 1) ? fd[i-1] : NODE_W'($urandom());
      send_edge(fs[i], fd[i], TIE_W'($urandom()), 1'b0);
    end
    for (int i = 0; i < 8; i++) begin
      pick = $urandom_range(DEPTH - 1);
      if (i % 2 == 0) send_edge(fs[pick], fd[pick], TIE_W'($urandom()), 1'b0);
      else send_edge(NODE_W'($urandom()), NODE_W'($urandom()), TIE_W'($urandom()), 1'b0);
    end
    if (stall_output) hold_go <= 1'b1;
    pick = $urandom_range(DEPTH - 1);
    if (last_is_new)
      send_edge(NODE_W'($urandom()), NODE_W'($urandom()), TIE_W'($urandom()), 1'b1);
    else send_edge(fs[pick], fd[pick], TIE_W'($urandom()), 1'b1);
  endtask

  // one key repeated past the count limit
  task automatic send_saturated_list();
    logic [NODE_W-1:0] ks;
    logic [NODE_W-1:0] kd;
    ks = NODE_W'($urandom());
    kd = NODE_W'($urandom());
    for (int i = 0; i < 3; i++)
      send_edge(NODE_W'($urandom()), NODE_W'($urandom()), TIE_W'($urandom()), 1'b0);
    for (int i = 0; i < 70; i++) send_edge(ks, kd, TIE_W'($urandom()), 1'b0);
    send_edge(ks, kd, TIE_W'($urandom()), 1'b1);
  endtask

  initial begin
    int list_no;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_edge('0, '0, '0, 1'b1);
    send_edge('1, '1, '1, 1'b1);
    send_edge(20'h00005, 20'hFFFFF, 8'h11, 1'b0);
    send_edge(20'hFFFFF, 20'h00005, 8'h22, 1'b0);
    send_edge(20'h00005, 20'hFFFFF, 8'h33, 1'b0);
    send_edge(20'h00000, 20'h00005, 8'h44, 1'b0);
    send_edge(20'h00001, 20'h00005, 8'h55, 1'b0);
    send_edge(20'h00000, 20'h00000, 8'hAA, 1'b0);
    send_edge(20'h12345, 20'hABCDE, 8'h5A, 1'b0);
    send_edge(20'hEDCBA, 20'h54321, 8'hA5, 1'b0);
    send_edge(20'h00000, 20'h00005, 8'hFF, 1'b1);
    send_edge(20'h00007, 20'h00009, 8'h01, 1'b0);
    send_edge(20'h00007, 20'h00009, 8'h02, 1'b0);
    send_edge(20'h00007, 20'h00009, 8'h03, 1'b1);
    wait_drained();

    list_no = 0;
    while (sent < ITEM_GOAL) begin
      calm <= (list_no >= 6 && list_no <= 10);
      case (list_no)
        2: send_full_list(1'b1, 1'b1);
        7: send_saturated_list();
        13: send_full_list(1'b0, 1'b0);
        default: send_short_list();
      endcase
      if (list_no == 0 || $urandom_range(99) < 25) wait_drained();
      list_no++;
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && open_results == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
